FILE: hdl/csma_pkg.sv
// shared types and constants for the credit switch arbiter
`default_nettype none

package csma_pkg;

  localparam int ID_W     = 31;
  localparam int PORT_W   = 2;
  localparam int CAP_W    = 4;
  localparam int MODE_W   = 2;
  localparam int IN_TDATA_W  = 40;
  localparam int OUT_TDATA_W = 40;

  localparam logic [CAP_W-1:0] CAP_RESET = 4'd8;

  typedef enum logic [MODE_W-1:0] {
    MODE_ARRIVAL   = 2'd0,
    MODE_TRANSFER  = 2'd1,
    MODE_SEND      = 2'd2,
    MODE_LINK_FREE = 2'd3
  } mode_t;

  // packed from the lowest bit up: credit_valid, credit_port, send_valid, sent_id, dropped
  typedef struct packed {
    logic              dropped;
    logic [ID_W-1:0]   sent_id;
    logic              send_valid;
    logic [PORT_W-1:0] credit_port;
    logic              credit_valid;
  } result_t;

  localparam int RESULT_W = $bits(result_t);

endpackage

`default_nettype wire

FILE: hdl/csma_fifo.sv
// id fifo with a registered head word, used for the entrance and exit queues
`default_nettype none

module csma_fifo #(
  parameter int DEPTH = 8,
  parameter int CW    = 4
) (
  input  wire logic                      clk,
  input  wire logic                      rst,
  input  wire logic                      push,
  input  wire logic [csma_pkg::ID_W-1:0] push_data,
  input  wire logic                      pop,
  output logic      [CW-1:0]             count,
  output logic      [csma_pkg::ID_W-1:0] head_data
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam logic [AW-1:0] LAST = AW'(DEPTH - 1);

  logic [csma_pkg::ID_W-1:0] mem [DEPTH];
  logic [AW-1:0] head, head_next;
  logic [AW-1:0] tail;

  always_comb begin
    head_next = head;
    if (pop) begin
      head_next = (head == LAST) ? '0 : head + AW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      head  <= '0;
      tail  <= '0;
      count <= '0;
    end else begin
      head <= head_next;
      if (push) begin
        tail  <= (tail == LAST) ? '0 : tail + AW'(1);
        count <= count + CW'(1);
      end else if (pop) begin
        count <= count - CW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem[tail] <= push_data;
    end
  end

  // head word follows the next read pointer; a write into that slot goes straight through
  always_ff @(posedge clk) begin
    if (push && tail == head_next) begin
      head_data <= push_data;
    end else begin
      head_data <= mem[head_next];
    end
  end

endmodule

`default_nettype wire

FILE: hdl/credit_switch_min_id_arbiter_unit.sv
// top level: entrance queues, smallest-id arbiter, exit queue and link state
// the result of an accepted item is written into the output register when the item is accepted
// one item per cycle unless stalled; arbitration, queue update and result settle in that cycle
// the output register frees the input side whenever it is empty or being drained
// reset (rst, synchronous) empties all queues, clears the link busy mark and sets capacity to 8
`default_nettype none

module credit_switch_min_id_arbiter_unit #(
  parameter int ENTRY_DEPTH = 8,
  parameter int EXIT_DEPTH  = 8,
  parameter int NUM_PORTS   = 3
) (
  input  wire logic                                clk,
  input  wire logic                                rst,
  input  wire logic                                s_axis_tvalid,
  output logic                                     s_axis_tready,
  // port [1:0], msg_id [32:2], zero fill above
  input  wire logic [csma_pkg::IN_TDATA_W-1:0]     s_axis_tdata,
  // mode [1:0]
  input  wire logic [csma_pkg::MODE_W-1:0]         s_axis_tuser,
  output logic                                     m_axis_tvalid,
  input  wire logic                                m_axis_tready,
  // credit_valid [0], credit_port [2:1], send_valid [3], sent_id [34:4], dropped [35]
  output logic      [csma_pkg::OUT_TDATA_W-1:0]    m_axis_tdata,
  input  wire logic                                cfg_valid,
  output logic                                     cfg_ready,
  input  wire logic [csma_pkg::CAP_W-1:0]          cfg_data
);

  localparam int ECW    = $clog2(ENTRY_DEPTH + 1);
  localparam int XCW    = $clog2(EXIT_DEPTH + 1);
  localparam int PSEL_W = (NUM_PORTS > 1) ? $clog2(NUM_PORTS) : 1;
  localparam int CMP_W  = (XCW > csma_pkg::CAP_W) ? XCW : csma_pkg::CAP_W;

  logic [csma_pkg::CAP_W-1:0] exit_capacity;
  logic                       link_busy;
  csma_pkg::result_t          res, res_next;
  logic                       res_valid;

  logic [ECW-1:0]            entry_count   [NUM_PORTS];
  logic [csma_pkg::ID_W-1:0] entry_head_id [NUM_PORTS];
  logic [NUM_PORTS-1:0]      entry_push, entry_pop;

  logic [XCW-1:0]            exit_count;
  logic [csma_pkg::ID_W-1:0] exit_head_id;
  logic                      exit_push, exit_pop;

  logic                        accept;
  csma_pkg::mode_t             mode;
  logic [csma_pkg::PORT_W-1:0] in_port;
  logic [csma_pkg::ID_W-1:0]   in_id;

  logic                      found;
  logic [PSEL_W-1:0]         best;
  logic [csma_pkg::ID_W-1:0] best_id;
  logic                      port_full;
  logic                      port_ok;
  logic                      room;
  logic                      do_xfer, do_send;

  assign s_axis_tready = !res_valid || m_axis_tready;
  assign accept        = s_axis_tvalid && s_axis_tready;
  assign cfg_ready     = 1'b1;

  assign mode    = csma_pkg::mode_t'(s_axis_tuser);
  assign in_port = s_axis_tdata[csma_pkg::PORT_W-1:0];
  assign in_id   = s_axis_tdata[csma_pkg::PORT_W +: csma_pkg::ID_W];

  // smallest head id among non-empty queues, lowest port on a tie
  always_comb begin
    found   = 1'b0;
    best    = '0;
    best_id = '0;
    for (int p = 0; p < NUM_PORTS; p++) begin
      if (entry_count[p] != '0 && (!found || entry_head_id[p] < best_id)) begin
        found   = 1'b1;
        best    = PSEL_W'(p);
        best_id = entry_head_id[p];
      end
    end
  end

  always_comb begin
    port_full = 1'b0;
    for (int p = 0; p < NUM_PORTS; p++) begin
      if (32'(in_port) == p && entry_count[p] == ECW'(ENTRY_DEPTH)) begin
        port_full = 1'b1;
      end
    end
  end

  assign port_ok = 32'(in_port) < NUM_PORTS;
  assign room    = (CMP_W'(exit_count) < CMP_W'(exit_capacity))
                && (exit_count != XCW'(EXIT_DEPTH));

  always_comb begin
    res_next   = '0;
    do_xfer    = 1'b0;
    do_send    = 1'b0;
    entry_push = '0;
    unique case (mode)
      csma_pkg::MODE_ARRIVAL: begin
        if (!port_ok || port_full) begin
          res_next.dropped = 1'b1;
        end else begin
          for (int p = 0; p < NUM_PORTS; p++) begin
            entry_push[p] = accept && 32'(in_port) == p;
          end
        end
      end
      csma_pkg::MODE_TRANSFER: begin
        if (room && found) begin
          do_xfer              = accept;
          res_next.credit_valid = 1'b1;
          res_next.credit_port  = csma_pkg::PORT_W'(best);
        end
      end
      csma_pkg::MODE_SEND: begin
        if (!link_busy && exit_count != '0) begin
          do_send             = accept;
          res_next.send_valid = 1'b1;
          res_next.sent_id    = exit_head_id;
        end
      end
      csma_pkg::MODE_LINK_FREE: begin
      end
      default: begin
      end
    endcase
  end

  always_comb begin
    for (int p = 0; p < NUM_PORTS; p++) begin
      entry_pop[p] = do_xfer && 32'(best) == p;
    end
  end

  assign exit_push = do_xfer;
  assign exit_pop  = do_send;

  for (genvar g = 0; g < NUM_PORTS; g++) begin : g_entry
    csma_fifo #(
      .DEPTH (ENTRY_DEPTH),
      .CW    (ECW)
    ) u_entry (
      .clk       (clk),
      .rst       (rst),
      .push      (entry_push[g]),
      .push_data (in_id),
      .pop       (entry_pop[g]),
      .count     (entry_count[g]),
      .head_data (entry_head_id[g])
    );
  end

  csma_fifo #(
    .DEPTH (EXIT_DEPTH),
    .CW    (XCW)
  ) u_exit (
    .clk       (clk),
    .rst       (rst),
    .push      (exit_push),
    .push_data (best_id),
    .pop       (exit_pop),
    .count     (exit_count),
    .head_data (exit_head_id)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      exit_capacity <= csma_pkg::CAP_RESET;
      link_busy     <= 1'b0;
      res_valid     <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        exit_capacity <= cfg_data;
      end
      if (do_send) begin
        link_busy <= 1'b1;
      end else if (accept && mode == csma_pkg::MODE_LINK_FREE) begin
        link_busy <= 1'b0;
      end
      if (accept) begin
        res_valid <= 1'b1;
      end else if (m_axis_tready) begin
        res_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      res <= res_next;
    end
  end

  assign m_axis_tvalid = res_valid;
  assign m_axis_tdata  = {(csma_pkg::OUT_TDATA_W - csma_pkg::RESULT_W)'(0), res};

endmodule

`default_nettype wire
